// File: src/sldf_pkg.sv
`timescale 1ns / 1ps

package sldf_pkg;

  localparam int unsigned MAX_PAYLOAD = 64;

  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [15:0] CRC_INIT        = 16'hFFFF;
  localparam logic [15:0] TIMEOUT_RESET   = 16'd1000;
  localparam logic [15:0] TICK_SATURATION = 16'hFFFF;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_SYNC_BYTE_0 = 3'd0,
    CFG_SYNC_BYTE_1 = 3'd1,
    CFG_SYNC_BYTE_2 = 3'd2,
    CFG_SYNC_BYTE_3 = 3'd3,
    CFG_END_BYTE    = 3'd4,
    CFG_TIMEOUT     = 3'd5
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ERR_SYNC = 3'd0,
    ERR_LEN  = 3'd1,
    ERR_CRC  = 3'd2,
    ERR_END  = 3'd3,
    ERR_TIME = 3'd4
  } err_kind_e;

  typedef enum logic {
    KIND_PAYLOAD = 1'b0,
    KIND_ERROR   = 1'b1
  } out_kind_e;

  typedef enum logic {
    OP_BYTE = 1'b0,
    OP_TICK = 1'b1
  } opcode_e;

  typedef enum logic [8:0] {
    PH_IDLE  = 9'b000000001,
    PH_SYNC1 = 9'b000000010,
    PH_SYNC2 = 9'b000000100,
    PH_SYNC3 = 9'b000001000,
    PH_LEN   = 9'b000010000,
    PH_DATA  = 9'b000100000,
    PH_CRC1  = 9'b001000000,
    PH_CRC2  = 9'b010000000,
    PH_END   = 9'b100000000
  } phase_e;

  typedef struct packed {
    logic wr_en;
    logic start;
  } store_cmd_t;

  typedef struct packed {
    logic       busy;
    logic       valid;
    logic [7:0] data;
    logic       last;
  } store_rsp_t;

  // CRC-16/CCITT-FALSE, one byte, poly 0x1021
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] x;
    x = {8'h00, crc[15:8] ^ b};
    x = x ^ (x >> 4);
    return (crc << 8) ^ (x << 12) ^ (x << 5) ^ x;
  endfunction

endpackage

// File: src/sldf_if.sv
`timescale 1ns / 1ps

interface sldf_in_if;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [7:0] rx_byte;

  modport source (output valid, output opcode, output rx_byte, input ready);
  modport sink   (input valid, input opcode, input rx_byte, output ready);
endinterface

interface sldf_out_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] payload_byte;
  logic       is_last;
  logic [2:0] error_kind;

  modport source (output valid, output kind, output payload_byte, output is_last,
                  output error_kind, input ready);
  modport sink   (input valid, input kind, input payload_byte, input is_last,
                  input error_kind, output ready);
endinterface

interface sldf_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [sldf_pkg::CFG_ADDR_W-1:0]  addr;
  logic [sldf_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, output addr, output data, input ready);
  modport sink   (input valid, input addr, input data, output ready);
endinterface

// File: src/sldf_store.sv
`timescale 1ns / 1ps

module sldf_store #(
  parameter int unsigned MAX_PAYLOAD = sldf_pkg::MAX_PAYLOAD,
  parameter int unsigned AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1,
  parameter int unsigned CW = $clog2(MAX_PAYLOAD + 1)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  sldf_pkg::store_cmd_t  cmd_i,
  input  logic [AW-1:0]         wr_addr_i,
  input  logic [7:0]            wr_data_i,
  input  logic [CW-1:0]         length_i,
  input  logic                  take_i,
  output sldf_pkg::store_rsp_t  rsp_o
);

  logic [7:0]    mem [MAX_PAYLOAD];
  logic [7:0]    rdata_q;
  logic [CW-1:0] issue_q, issue_d;
  logic [CW-1:0] len_q, len_d;
  logic          busy_q, busy_d;
  logic          pend_q, pend_d;
  logic          last_q, last_d;
  logic          issue;
  logic [CW-1:0] issue_nxt;

  assign issue     = busy_q && (!pend_q || take_i);
  assign issue_nxt = issue_q + CW'(1);

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (issue) begin
      rdata_q <= mem[issue_q[AW-1:0]];
    end
  end

  always_comb begin
    issue_d = issue_q;
    len_d   = len_q;
    busy_d  = busy_q;
    pend_d  = pend_q;
    last_d  = last_q;
    if (take_i) begin
      pend_d = 1'b0;
    end
    if (issue) begin
      pend_d  = 1'b1;
      issue_d = issue_nxt;
      last_d  = (issue_nxt == len_q);
      if (issue_nxt == len_q) begin
        busy_d = 1'b0;
      end
    end
    if (cmd_i.start) begin
      busy_d  = 1'b1;
      issue_d = '0;
      len_d   = length_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      issue_q <= '0;
      len_q   <= '0;
      busy_q  <= 1'b0;
      pend_q  <= 1'b0;
      last_q  <= 1'b0;
    end else begin
      issue_q <= issue_d;
      len_q   <= len_d;
      busy_q  <= busy_d;
      pend_q  <= pend_d;
      last_q  <= last_d;
    end
  end

  assign rsp_o.busy  = busy_q;
  assign rsp_o.valid = pend_q;
  assign rsp_o.data  = rdata_q;
  assign rsp_o.last  = last_q;

endmodule

// File: src/sync_length_crc_packet_deframer_top.sv
`timescale 1ns / 1ps

// Frame deframer: four sync bytes, a length byte (1..MAX_PAYLOAD), payload, a big-endian
// CRC-16/CCITT-FALSE over the payload and a terminator byte. Each input transaction is a
// byte or a time tick and is taken while a frame is parsed, unless the output register is
// stalled; payload bytes go into a payload RAM as they arrive. After a good terminator
// the payload is read back from that RAM through its registered read port, one byte per
// cycle while the output is not stalled, and input is held off until the read-out has
// drained into the output register. Faults produce one error transaction and return the
// parser to idle. Ticks count only outside idle, from the first sync byte. The RAM needs
// no clearing after reset.
module sync_length_crc_packet_deframer_top #(
  parameter int unsigned MAX_PAYLOAD = sldf_pkg::MAX_PAYLOAD
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  sldf_in_if.sink    in_i,
  sldf_out_if.source out_o,
  sldf_cfg_if.sink   cfg_i
);

  localparam int unsigned AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam int unsigned CW = $clog2(MAX_PAYLOAD + 1);
  localparam logic [7:0]  LEN_MAX = 8'(MAX_PAYLOAD);

  logic [7:0]  sync0_q, sync1_q, sync2_q, sync3_q, end_q;
  logic [15:0] timeout_q;

  sldf_pkg::phase_e phase_q, phase_d;
  logic [CW-1:0]    len_q, len_d;
  logic [CW-1:0]    idx_q, idx_d;
  logic [15:0]      crc_q, crc_d;
  logic [7:0]       crc_hi_q, crc_hi_d;
  logic [15:0]      ticks_q, ticks_d;
  logic [15:0]      ticks_inc;

  logic       out_valid_q, out_valid_d;
  logic       out_kind_q, out_kind_d;
  logic [7:0] out_byte_q, out_byte_d;
  logic       out_last_q, out_last_d;
  logic [2:0] out_err_q, out_err_d;

  sldf_pkg::store_cmd_t  cmd;
  sldf_pkg::store_rsp_t  rsp;
  logic                  take;
  logic                  in_ready;
  logic                  acc;
  logic                  err_fire;
  sldf_pkg::err_kind_e   err_code;
  logic [7:0]            b;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync0_q   <= '0;
      sync1_q   <= '0;
      sync2_q   <= '0;
      sync3_q   <= '0;
      end_q     <= '0;
      timeout_q <= sldf_pkg::TIMEOUT_RESET;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.addr)
        sldf_pkg::CFG_SYNC_BYTE_0: sync0_q   <= cfg_i.data[7:0];
        sldf_pkg::CFG_SYNC_BYTE_1: sync1_q   <= cfg_i.data[7:0];
        sldf_pkg::CFG_SYNC_BYTE_2: sync2_q   <= cfg_i.data[7:0];
        sldf_pkg::CFG_SYNC_BYTE_3: sync3_q   <= cfg_i.data[7:0];
        sldf_pkg::CFG_END_BYTE:    end_q     <= cfg_i.data[7:0];
        sldf_pkg::CFG_TIMEOUT:     timeout_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  assign in_ready   = !rsp.busy && !rsp.valid && (!out_valid_q || out_o.ready);
  assign in_i.ready = in_ready;
  assign acc        = in_i.valid && in_ready;
  assign b          = in_i.rx_byte;
  assign ticks_inc  = (ticks_q == sldf_pkg::TICK_SATURATION) ? ticks_q : ticks_q + 16'd1;

  always_comb begin
    phase_d   = phase_q;
    len_d     = len_q;
    idx_d     = idx_q;
    crc_d     = crc_q;
    crc_hi_d  = crc_hi_q;
    ticks_d   = ticks_q;
    err_fire  = 1'b0;
    err_code  = sldf_pkg::ERR_SYNC;
    cmd.wr_en = 1'b0;
    cmd.start = 1'b0;

    if (acc) begin
      if (in_i.opcode == sldf_pkg::OP_TICK) begin
        if (phase_q != sldf_pkg::PH_IDLE) begin
          ticks_d = ticks_inc;
          if (ticks_inc >= timeout_q) begin
            err_fire = 1'b1;
            err_code = sldf_pkg::ERR_TIME;
          end
        end
      end else begin
        unique case (phase_q)
          sldf_pkg::PH_IDLE: begin
            if (b == sync0_q) begin
              phase_d = sldf_pkg::PH_SYNC1;
              ticks_d = '0;
            end
          end
          sldf_pkg::PH_SYNC1: begin
            if (b == sync1_q) phase_d = sldf_pkg::PH_SYNC2;
            else err_fire = 1'b1;
          end
          sldf_pkg::PH_SYNC2: begin
            if (b == sync2_q) phase_d = sldf_pkg::PH_SYNC3;
            else err_fire = 1'b1;
          end
          sldf_pkg::PH_SYNC3: begin
            if (b == sync3_q) phase_d = sldf_pkg::PH_LEN;
            else err_fire = 1'b1;
          end
          sldf_pkg::PH_LEN: begin
            if (b == 8'd0 || b > LEN_MAX) begin
              err_fire = 1'b1;
              err_code = sldf_pkg::ERR_LEN;
            end else begin
              len_d   = b[CW-1:0];
              idx_d   = '0;
              crc_d   = sldf_pkg::CRC_INIT;
              phase_d = sldf_pkg::PH_DATA;
            end
          end
          sldf_pkg::PH_DATA: begin
            cmd.wr_en = 1'b1;
            crc_d     = sldf_pkg::crc16_byte(crc_q, b);
            idx_d     = idx_q + CW'(1);
            if (idx_d >= len_q) phase_d = sldf_pkg::PH_CRC1;
          end
          sldf_pkg::PH_CRC1: begin
            crc_hi_d = b;
            phase_d  = sldf_pkg::PH_CRC2;
          end
          sldf_pkg::PH_CRC2: begin
            if ({crc_hi_q, b} != crc_q) begin
              err_fire = 1'b1;
              err_code = sldf_pkg::ERR_CRC;
            end else begin
              phase_d = sldf_pkg::PH_END;
            end
          end
          sldf_pkg::PH_END: begin
            if (b != end_q) begin
              err_fire = 1'b1;
              err_code = sldf_pkg::ERR_END;
            end else begin
              cmd.start = 1'b1;
            end
          end
          default: ;
        endcase
      end

      if (err_fire || cmd.start) begin
        phase_d  = sldf_pkg::PH_IDLE;
        len_d    = '0;
        idx_d    = '0;
        crc_d    = sldf_pkg::CRC_INIT;
        crc_hi_d = '0;
        ticks_d  = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= sldf_pkg::PH_IDLE;
      len_q    <= '0;
      idx_q    <= '0;
      crc_q    <= sldf_pkg::CRC_INIT;
      crc_hi_q <= '0;
      ticks_q  <= '0;
    end else begin
      phase_q  <= phase_d;
      len_q    <= len_d;
      idx_q    <= idx_d;
      crc_q    <= crc_d;
      crc_hi_q <= crc_hi_d;
      ticks_q  <= ticks_d;
    end
  end

  sldf_store #(
    .MAX_PAYLOAD (MAX_PAYLOAD),
    .AW          (AW),
    .CW          (CW)
  ) u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .wr_addr_i (idx_q[AW-1:0]),
    .wr_data_i (b),
    .length_i  (len_q),
    .take_i    (take),
    .rsp_o     (rsp)
  );

  assign take = rsp.valid && (!out_valid_q || out_o.ready);

  always_comb begin
    out_valid_d = out_valid_q;
    out_kind_d  = out_kind_q;
    out_byte_d  = out_byte_q;
    out_last_d  = out_last_q;
    out_err_d   = out_err_q;
    if (out_o.ready) out_valid_d = 1'b0;
    if (err_fire) begin
      out_valid_d = 1'b1;
      out_kind_d  = sldf_pkg::KIND_ERROR;
      out_byte_d  = '0;
      out_last_d  = 1'b1;
      out_err_d   = err_code;
    end else if (take) begin
      out_valid_d = 1'b1;
      out_kind_d  = sldf_pkg::KIND_PAYLOAD;
      out_byte_d  = rsp.data;
      out_last_d  = rsp.last;
      out_err_d   = sldf_pkg::ERR_SYNC;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_kind_q <= out_kind_d;
    out_byte_q <= out_byte_d;
    out_last_q <= out_last_d;
    out_err_q  <= out_err_d;
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.kind         = out_kind_q;
  assign out_o.payload_byte = out_byte_q;
  assign out_o.is_last      = out_last_q;
  assign out_o.error_kind   = out_err_q;

endmodule
